>>> rtl/apif_pkg.sv
// ----------------------------------------------------------------------------
// apif_pkg
// Shared types and constants for the alpha plane inverse filter.
// ----------------------------------------------------------------------------
package apif_pkg;

   localparam int APIF_DATA_W    = 8;
   localparam int APIF_COUNT_W   = 14;
   localparam int APIF_MAX_WIDTH = 16384;
   localparam int APIF_CSR_IDX_W = 2;

   typedef enum logic [APIF_CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_FILTER_MODE  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FILTER_NONE       = 2'd0,
      FILTER_HORIZONTAL = 2'd1,
      FILTER_VERTICAL   = 2'd2,
      FILTER_GRADIENT   = 2'd3
   } filter_mode_type;

   // Position flags of the item in the reconstruct stage.
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic in_range;
      logic end_of_row;
      logic end_of_frame;
   } pos_type;

endpackage

>>> rtl/apif_ram.sv
// ----------------------------------------------------------------------------
// apif_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module apif_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/apif_recon.sv
// ----------------------------------------------------------------------------
// apif_recon
// Predictor select and add; holds the left and upper-left pixels.
// ----------------------------------------------------------------------------
module apif_recon
   import apif_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  filter_mode_type        mode,
   input  pos_type                pos,
   input  logic [APIF_DATA_W-1:0] residual,
   input  logic [APIF_DATA_W-1:0] above,
   output logic [APIF_DATA_W-1:0] alpha
);

   logic [APIF_DATA_W-1:0] left_ff, left_in;
   logic [APIF_DATA_W-1:0] upleft_ff, upleft_in;
   logic [APIF_DATA_W-1:0] pred;
   logic signed [APIF_DATA_W+1:0] grad;

   always_comb begin
      grad = $signed({2'b00, left_ff}) + $signed({2'b00, above})
           - $signed({2'b00, upleft_ff});
      pred = '0;
      if (mode != FILTER_NONE) begin
         if (pos.first_row && pos.first_col) begin
            pred = '0;
         end else if (pos.first_row) begin
            pred = left_ff;
         end else if (pos.first_col) begin
            pred = above;
         end else begin
            case (mode)
               FILTER_HORIZONTAL: pred = left_ff;
               FILTER_VERTICAL:   pred = above;
               FILTER_GRADIENT: begin
                  if (grad < 0) begin
                     pred = '0;
                  end else if (grad > 255) begin
                     pred = '1;
                  end else begin
                     pred = grad[APIF_DATA_W-1:0];
                  end
               end
               default: pred = '0;
            endcase
         end
      end
      alpha     = residual + pred;
      left_in   = advance ? alpha : left_ff;
      upleft_in = advance ? above : upleft_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         upleft_ff <= '0;
      end else begin
         left_ff   <= left_in;
         upleft_ff <= upleft_in;
      end
   end

endmodule

>>> rtl/alpha_plane_inverse_filter_unit.sv
// ----------------------------------------------------------------------------
// alpha_plane_inverse_filter_unit
// Undoes the spatial prediction of an alpha plane, one byte per item, using
// a line store of the previous reconstructed row.
//
//   channel | dir | payload
//   req_    | in  | tdata = residual
//   rsp_    | out | tdata = alpha_value, tlast = end_of_row,
//           |     | tuser = end_of_frame
//   csr_    | in  | index 0 width, 1 height, 2 filter mode
//
// One item per cycle sustained while rsp_tready allows. Accept reads the line
// store at the column count as the item enters the s1 register; from s1 the
// predictor is added, the line store updated and the output register loaded.
// Width-one rows forward the pending write to the next read.
// Synchronous reset clears counters, neighbors and valids; no clearing pass.
// ----------------------------------------------------------------------------
module alpha_plane_inverse_filter_unit
   import apif_pkg::*;
#(
   parameter int MAX_WIDTH = APIF_MAX_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [APIF_DATA_W-1:0]    req_tdata,   // [7:0] residual
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [APIF_DATA_W-1:0]    rsp_tdata,   // [7:0] alpha_value
   output logic                      rsp_tlast,
   output logic                      rsp_tuser,   // [0] end_of_frame
   input  logic                      csr_we,
   input  logic [APIF_CSR_IDX_W-1:0] csr_index,
   input  logic [APIF_COUNT_W-1:0]   csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam logic [APIF_COUNT_W:0] MAX_W_C = (APIF_COUNT_W+1)'(MAX_WIDTH);

   logic [APIF_COUNT_W-1:0] width_ff, height_ff;
   filter_mode_type         mode_ff;

   logic [APIF_COUNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [APIF_COUNT_W:0]   width_eff, height_eff;
   logic                    last_col, last_row, in_range, accept;

   logic                    s1_valid_ff, s1_valid_in;
   pos_type                 s1_pos_ff, pos_new;
   logic [APIF_DATA_W-1:0]  s1_res_ff;
   logic [ADDR_W-1:0]       s1_addr_ff;
   logic                    s1_fwd_ff, fwd_new;
   logic [APIF_DATA_W-1:0]  s1_fwd_data_ff;
   logic                    s1_adv;

   logic [APIF_DATA_W-1:0]  ram_rdata, above, alpha;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [APIF_DATA_W-1:0]  rsp_data_ff;
   logic                    rsp_last_ff, rsp_user_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= APIF_COUNT_W'(1);
         height_ff <= APIF_COUNT_W'(1);
         mode_ff   <= FILTER_NONE;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_FILTER_MODE:  mode_ff   <= filter_mode_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   // position and handshake
   always_comb begin
      s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = !s1_valid_ff || s1_adv;
      accept     = req_tvalid && req_tready;

      if (width_ff == '0) begin
         width_eff = (APIF_COUNT_W+1)'(1);
      end else if ({1'b0, width_ff} > MAX_W_C) begin
         width_eff = MAX_W_C;
      end else begin
         width_eff = {1'b0, width_ff};
      end
      height_eff = (height_ff == '0) ? (APIF_COUNT_W+1)'(1) : {1'b0, height_ff};

      last_col = {1'b0, col_ff} >= width_eff - 1'b1;
      last_row = {1'b0, row_ff} >= height_eff - 1'b1;
      in_range = {1'b0, col_ff} < MAX_W_C;

      pos_new.first_row    = (row_ff == '0);
      pos_new.first_col    = (col_ff == '0);
      pos_new.in_range     = in_range;
      pos_new.end_of_row   = last_col;
      pos_new.end_of_frame = last_col && last_row;

      fwd_new = s1_adv && s1_pos_ff.in_range && in_range
             && (s1_addr_ff == col_ff[ADDR_W-1:0]);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end

      s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff      <= pos_new;
         s1_res_ff      <= req_tdata;
         s1_addr_ff     <= col_ff[ADDR_W-1:0];
         s1_fwd_ff      <= fwd_new;
         s1_fwd_data_ff <= alpha;
      end
      if (s1_adv) begin
         rsp_data_ff <= alpha;
         rsp_last_ff <= s1_pos_ff.end_of_row;
         rsp_user_ff <= s1_pos_ff.end_of_frame;
      end
   end

   apif_ram #(
      .DATA_W (APIF_DATA_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_adv && s1_pos_ff.in_range),
      .wr_addr (s1_addr_ff),
      .wr_data (alpha),
      .rd_en   (accept),
      .rd_addr (col_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (!s1_pos_ff.in_range) begin
         above = '0;
      end else if (s1_fwd_ff) begin
         above = s1_fwd_data_ff;
      end else begin
         above = ram_rdata;
      end
   end

   apif_recon u_recon (
      .clock    (clock),
      .reset    (reset),
      .advance  (s1_adv),
      .mode     (mode_ff),
      .pos      (s1_pos_ff),
      .residual (s1_res_ff),
      .above    (above),
      .alpha    (alpha)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> bench/alpha_filter_checker.sv
// ----------------------------------------------------------------------------
// alpha_filter_checker
// Watches the request, result and register ports of the alpha plane inverse
// filter. It keeps its own line store, neighbor pixels and position counters,
// predicts each reconstructed alpha item on acceptance, and compares results
// in order against the queue of predicted pixels.
// ----------------------------------------------------------------------------
module alpha_filter_checker
   import apif_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [APIF_DATA_W-1:0]    req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [APIF_DATA_W-1:0]    rsp_tdata,
   input  logic                      rsp_tlast,
   input  logic                      rsp_tuser,
   input  logic                      csr_we,
   input  logic [APIF_CSR_IDX_W-1:0] csr_index,
   input  logic [APIF_COUNT_W-1:0]   csr_wdata,
   output int                        mismatch_count,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [APIF_DATA_W-1:0] alpha_value;
      logic                   end_of_row;
      logic                   end_of_frame;
   } alpha_pixel_type;

   logic [APIF_DATA_W-1:0]  prev_row [APIF_MAX_WIDTH];
   logic [APIF_DATA_W-1:0]  left_q;
   logic [APIF_DATA_W-1:0]  upleft_q;
   logic [APIF_COUNT_W-1:0] column_q;
   logic [APIF_COUNT_W-1:0] row_q;
   logic [APIF_COUNT_W-1:0] width_q;
   logic [APIF_COUNT_W-1:0] height_q;
   filter_mode_type         mode_q;
   alpha_pixel_type         expected_pixels [$];

   // Reconstructs one pixel and advances the filter state.
   function automatic alpha_pixel_type reconstruct_pixel(
      input logic [APIF_DATA_W-1:0] residual);
      int unsigned            eff_width;
      int unsigned            eff_height;
      int                     gradient;
      logic [APIF_DATA_W-1:0] above;
      logic [APIF_DATA_W-1:0] pred;
      alpha_pixel_type        pix;
      eff_width  = (width_q == 0) ? 1 : width_q;
      eff_height = (height_q == 0) ? 1 : height_q;
      above      = prev_row[column_q];
      pred       = '0;
      if (mode_q != FILTER_NONE) begin
         if (row_q == 0 && column_q == 0) begin
            pred = '0;
         end else if (row_q == 0) begin
            pred = left_q;
         end else if (column_q == 0) begin
            pred = above;
         end else begin
            case (mode_q)
               FILTER_HORIZONTAL: pred = left_q;
               FILTER_VERTICAL:   pred = above;
               default: begin
                  gradient = int'(left_q) + int'(above) - int'(upleft_q);
                  if (gradient < 0) pred = 8'h00;
                  else if (gradient > 255) pred = 8'hFF;
                  else pred = gradient[APIF_DATA_W-1:0];
               end
            endcase
         end
      end
      pix.alpha_value  = residual + pred;
      pix.end_of_row   = (column_q >= eff_width - 1);
      pix.end_of_frame = pix.end_of_row && (row_q >= eff_height - 1);
      upleft_q           = above;
      left_q             = pix.alpha_value;
      prev_row[column_q] = pix.alpha_value;
      if (pix.end_of_row) begin
         column_q = '0;
         row_q    = pix.end_of_frame ? '0 : row_q + 1'b1;
      end else begin
         column_q = column_q + 1'b1;
      end
      return pix;
   endfunction

   always @(posedge clock) begin : watch
      alpha_pixel_type got;
      alpha_pixel_type want;
      if (reset) begin
         foreach (prev_row[i]) prev_row[i] = '0;
         left_q         = '0;
         upleft_q       = '0;
         column_q       = '0;
         row_q          = '0;
         width_q        = 14'd1;
         height_q       = 14'd1;
         mode_q         = FILTER_NONE;
         mismatch_count = 0;
         expected_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tlast, rsp_tuser};
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected item alpha %02h eor %0b eof %0b", $time,
                           got.alpha_value, got.end_of_row, got.end_of_frame);
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: alpha exp %02h got %02h, eor exp %0b got %0b,",
                               " eof exp %0b got %0b"},
                              $time, want.alpha_value, got.alpha_value, want.end_of_row,
                              got.end_of_row, want.end_of_frame, got.end_of_frame);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_pixels.push_back(reconstruct_pixel(req_tdata));
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_q  = csr_wdata;
               CSR_IMAGE_HEIGHT: height_q = csr_wdata;
               CSR_FILTER_MODE:  mode_q   = filter_mode_type'(csr_wdata[1:0]);
               default: ;
            endcase
         end
      end
      outstanding = expected_pixels.size();
   end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the alpha plane inverse filter. Runs the reset defaults, a
// row as wide as the widest random frame, small frames in every mode, zero
// sizes, counters left beyond a shrunk frame, a tall column and then random
// frame shapes with random idling on both sides.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;
   import apif_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                        CYCLE_LIMIT      = 1_000_000;
   localparam int                        RANDOM_ITEMS     = 1100;
   localparam int                        MAX_FRAME_W      = 400;
   localparam int                        TALL_ROWS        = 40;
   localparam logic [APIF_CSR_IDX_W-1:0] CSR_SPARE        = 2'd3;
   localparam logic [47:0]               CORNER_RESIDUALS = 48'hFE_01_7F_80_00_FF;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [APIF_DATA_W-1:0]    req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [APIF_DATA_W-1:0]    rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tuser;
   logic                      csr_we;
   logic [APIF_CSR_IDX_W-1:0] csr_index;
   logic [APIF_COUNT_W-1:0]   csr_wdata;
   int                        mismatch_count;
   int                        outstanding;
   bit                        steady;

   alpha_plane_inverse_filter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] residual
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] alpha_value
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),    // [0] end_of_frame
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   alpha_filter_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_tready = steady || ($urandom_range(99) >= 27);
   end

   task automatic push_residual(input logic [APIF_DATA_W-1:0] residual);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 27) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = residual;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted pixel has come back.
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [APIF_CSR_IDX_W-1:0] index,
                            input logic [APIF_COUNT_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic set_frame(input int width, input int height, input filter_mode_type mode);
      write_csr(CSR_IMAGE_WIDTH, APIF_COUNT_W'(width));
      write_csr(CSR_IMAGE_HEIGHT, APIF_COUNT_W'(height));
      write_csr(CSR_FILTER_MODE, APIF_COUNT_W'(mode));
   endtask

   function automatic logic [APIF_DATA_W-1:0] pick_residual();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return 8'h00;
      if (roll < 10) return 8'hFF;
      return APIF_DATA_W'($urandom_range(255));
   endfunction

   task automatic send_random(input int count);
      repeat (count) push_residual(pick_residual());
   endtask

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int              width;
      int              height;
      int              frame_items;
      int              burst;
      int              random_sent;
      int              roll;
      filter_mode_type mode;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_IMAGE_WIDTH;
      csr_wdata  = '0;
      steady     = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // reset defaults: 1x1 frames, no filtering
      for (int k = 0; k < 6; k++) push_residual(CORNER_RESIDUALS[8*k +: 8]);

      // widest frame row writes every line store entry in use
      settle();
      set_frame(MAX_FRAME_W, 1, FILTER_HORIZONTAL);
      send_random(MAX_FRAME_W);

      for (int m = 0; m < 4; m++) begin
         settle();
         set_frame(3, 2, filter_mode_type'(2'(m)));
         for (int k = 0; k < 6; k++) push_residual(CORNER_RESIDUALS[8*k +: 8]);
      end

      // zero sizes act as one
      settle();
      set_frame(0, 0, FILTER_GRADIENT);
      push_residual(8'h5A);
      push_residual(8'hA5);

      // counters left beyond a shrunk frame, mode change mid-frame
      settle();
      set_frame(6, 3, FILTER_VERTICAL);
      send_random(8);
      settle();
      write_csr(CSR_IMAGE_WIDTH, 14'd2);
      send_random(3);
      settle();
      write_csr(CSR_IMAGE_HEIGHT, 14'd1);
      send_random(2);
      settle();
      write_csr(CSR_FILTER_MODE, APIF_COUNT_W'(FILTER_GRADIENT));
      write_csr(CSR_SPARE, 14'h3FFF);
      send_random(4);

      // tall column, width one
      settle();
      set_frame(1, TALL_ROWS, FILTER_GRADIENT);
      send_random(TALL_ROWS);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         roll = $urandom_range(99);
         if (roll < 4) width = 0;
         else if (roll < 60) width = $urandom_range(1, 8);
         else if (roll < 90) width = $urandom_range(9, 40);
         else width = $urandom_range(41, MAX_FRAME_W);
         roll = $urandom_range(99);
         if (roll < 4) height = 0;
         else if (width > 40) height = $urandom_range(1, 2);
         else height = $urandom_range(1, 6);
         mode = filter_mode_type'(2'($urandom_range(3)));
         set_frame(width, height, mode);
         frame_items = (width == 0 ? 1 : width) * (height == 0 ? 1 : height);
         if ($urandom_range(3) == 0) burst = $urandom_range(1, 2 * frame_items);
         else burst = frame_items * $urandom_range(1, 3);
         if (burst > RANDOM_ITEMS - random_sent) burst = RANDOM_ITEMS - random_sent;
         repeat (burst) begin
            steady = (random_sent >= 600 && random_sent < 1000);
            if (random_sent == 300) settle();
            push_residual(pick_residual());
            random_sent++;
         end
      end
      steady = 1'b0;
      settle();

      if (mismatch_count == 0 && outstanding == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
